// ===== rtl/skt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the sorted key table.
// No dependencies.
package skt_pkg;

  localparam int DEF_CAPACITY = 64;
  localparam int DEF_KEY_BITS = 32;

  localparam int KEY_IN_W = 32;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 7;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_ERASE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_ERASED    = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  // Row-wide control broadcast to every cell
  typedef struct packed {
    logic cmp;
    logic ins;
    logic del;
  } skt_ctl_t;

endpackage

// ===== rtl/skt_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channels for operation items and result items.
// Depends on skt_pkg.
interface skt_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [skt_pkg::KEY_IN_W-1:0] key;

  modport source (output valid, mode, key, input ready);
  modport sink   (input valid, mode, key, output ready);
endinterface

interface skt_out_if;
  logic                        valid;
  logic                        ready;
  logic [skt_pkg::STATUS_W-1:0] status;
  logic [skt_pkg::POS_W-1:0]    position;
  logic [skt_pkg::KEY_IN_W-1:0] removed_key;
  logic [skt_pkg::POS_W-1:0]    entry_count;

  modport source (output valid, status, position, removed_key, entry_count, input ready);
  modport sink   (input valid, status, position, removed_key, entry_count, output ready);
endinterface

// ===== rtl/skt_cell.sv =====
`timescale 1ns / 1ps
// One slot of the sorted row: stored key, compare flags and shift mux.
// Depends on skt_pkg.
module skt_cell #(
  parameter int KEY_BITS = skt_pkg::DEF_KEY_BITS,
  parameter int CAP_W    = 7,
  parameter int INDEX    = 0
) (
  input  logic                clk,
  input  skt_pkg::skt_ctl_t   ctl,
  input  logic                signed_order,
  input  logic [CAP_W-1:0]    count,
  input  logic [KEY_BITS-1:0] key,
  input  logic [KEY_BITS-1:0] left_key,
  input  logic [KEY_BITS-1:0] right_key,
  input  logic                left_lt,
  output logic [KEY_BITS-1:0] cell_key,
  output logic                lt,
  output logic                at_pos,
  output logic                eq
);
  import skt_pkg::*;

  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic                lt_r, eq_r;
  logic                occ;
  logic [KEY_BITS-1:0] ord_a, ord_b;

  assign occ   = count > CAP_W'(INDEX);
  assign ord_a = {key_r[KEY_BITS-1] ^ signed_order, key_r[KEY_BITS-2:0]};
  assign ord_b = {key[KEY_BITS-1] ^ signed_order, key[KEY_BITS-2:0]};

  always_comb begin
    key_nxt = key_r;
    if (ctl.ins && !lt_r) begin
      key_nxt = left_lt ? key : left_key;
    end else if (ctl.del && !lt_r) begin
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    if (ctl.cmp) begin
      lt_r <= occ && (ord_a < ord_b);
      eq_r <= occ && (key_r == key);
    end
  end

  assign cell_key = key_r;
  assign lt       = lt_r;
  assign at_pos   = !lt_r && left_lt;
  assign eq       = eq_r;

endmodule

// ===== rtl/skt_pos_enc.sv =====
`timescale 1ns / 1ps
// Turns the row's one-hot boundary into a position and a hit flag.
// Depends on skt_pkg.
module skt_pos_enc #(
  parameter int CAPACITY = skt_pkg::DEF_CAPACITY,
  parameter int CAP_W    = 7
) (
  input  logic [CAPACITY-1:0] at_pos,
  input  logic [CAPACITY-1:0] eq,
  output logic [CAP_W-1:0]    pos,
  output logic                hit
);
  import skt_pkg::*;

  logic [CAP_W-1:0] enc;

  always_comb begin
    enc = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (at_pos[i]) enc = enc | CAP_W'(i);
    end
    pos = (|at_pos) ? enc : CAP_W'(CAPACITY);
    hit = |(at_pos & eq);
  end

endmodule

// ===== rtl/sorted_key_table.sv =====
`timescale 1ns / 1ps
// Sorted key table: holds up to CAPACITY distinct keys in ascending order (unsigned, or two's
// complement when cfg_wdata sets signed order) in a row of cells. An item inserts or erases
// one key and yields one result item with status, position, removed key and count. Each item
// passes three states: S_IDLE latches it, in S_CMP every cell compares its key in parallel,
// and in S_COMMIT the row shifts and the result is registered; the commit waits while an
// earlier result is still unread. A new item is taken once the previous one has committed.
// Depends on skt_pkg, skt_if, skt_cell and skt_pos_enc.
module sorted_key_table #(
  parameter int CAPACITY = skt_pkg::DEF_CAPACITY,
  parameter int KEY_BITS = skt_pkg::DEF_KEY_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  skt_in_if.sink     in_ch,
  skt_out_if.source  out_ch
);
  import skt_pkg::*;

  localparam int CAP_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_COMMIT} state_t;

  state_t              state_r;
  logic                signed_order_r;
  logic                mode_r;
  logic [KEY_BITS-1:0] key_r;
  logic [CAP_W-1:0]    count_r, count_nxt;
  logic                out_valid_r;
  status_t             status_r, status_nxt;
  logic [POS_W-1:0]    position_r;
  logic [KEY_IN_W-1:0] removed_r, removed_nxt;
  logic [POS_W-1:0]    entry_count_r;

  skt_ctl_t            ctl;
  logic                commit_go;
  logic                full;
  logic [CAP_W-1:0]    pos;
  logic                hit;

  logic [KEY_BITS-1:0] cell_key [CAPACITY];
  logic [CAPACITY-1:0] lt, at_pos, eq;

  assign in_ch.ready = (state_r == S_IDLE);
  assign commit_go   = (state_r == S_COMMIT) && (!out_valid_r || out_ch.ready);
  assign full        = (count_r == CAP_W'(CAPACITY));

  always_comb begin
    ctl.cmp = (state_r == S_CMP);
    ctl.ins = commit_go && (mode_r == MODE_INSERT) && !hit && !full;
    ctl.del = commit_go && (mode_r == MODE_ERASE) && hit;
  end

  always_comb begin
    count_nxt   = count_r;
    removed_nxt = '0;
    if (mode_r == MODE_INSERT) begin
      if (hit) begin
        status_nxt = ST_DUPLICATE;
      end else if (full) begin
        status_nxt = ST_FULL;
      end else begin
        status_nxt = ST_INSERTED;
        count_nxt  = count_r + CAP_W'(1);
      end
    end else begin
      if (hit) begin
        status_nxt  = ST_ERASED;
        count_nxt   = count_r - CAP_W'(1);
        removed_nxt = KEY_IN_W'(key_r);
      end else begin
        status_nxt = ST_NOT_FOUND;
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [KEY_BITS-1:0] left_key, right_key;
    logic                left_lt;
    if (g == 0) begin : g_first
      assign left_key = key_r;
      assign left_lt  = 1'b1;
    end else begin : g_mid
      assign left_key = cell_key[g-1];
      assign left_lt  = lt[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_key = cell_key[g];
    end else begin : g_inner
      assign right_key = cell_key[g+1];
    end

    skt_cell #(
      .KEY_BITS (KEY_BITS),
      .CAP_W    (CAP_W),
      .INDEX    (g)
    ) u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .signed_order (signed_order_r),
      .count        (count_r),
      .key          (key_r),
      .left_key     (left_key),
      .right_key    (right_key),
      .left_lt      (left_lt),
      .cell_key     (cell_key[g]),
      .lt           (lt[g]),
      .at_pos       (at_pos[g]),
      .eq           (eq[g])
    );
  end

  skt_pos_enc #(
    .CAPACITY (CAPACITY),
    .CAP_W    (CAP_W)
  ) u_pos_enc (
    .at_pos (at_pos),
    .eq     (eq),
    .pos    (pos),
    .hit    (hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_order_r <= 1'b0;
    end else if (cfg_we) begin
      signed_order_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (commit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            mode_r  <= in_ch.mode;
            key_r   <= KEY_BITS'(in_ch.key);
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          state_r <= S_COMMIT;
        end
        S_COMMIT: begin
          if (commit_go) begin
            count_r       <= count_nxt;
            status_r      <= status_nxt;
            position_r    <= POS_W'(pos);
            removed_r     <= removed_nxt;
            entry_count_r <= POS_W'(count_nxt);
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.position    = position_r;
  assign out_ch.removed_key = removed_r;
  assign out_ch.entry_count = entry_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_W'(CAPACITY))
    else $error("entry count above capacity");

  a_boundary_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMMIT) |-> $onehot0(at_pos))
    else $error("more than one insertion boundary in the row");

  a_no_ins_del: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.ins && ctl.del))
    else $error("row told to shift both ways");

  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_COMMIT))
    else $error("result raised outside commit");

  a_full_boundary: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMMIT && !full) |-> (at_pos != '0))
    else $error("no boundary found in a table with a free slot");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sorted_key_table: random insert/erase traffic against a behavioral
// copy of the key table, under both key orders, with random stalls on both channels.
// Depends on skt_pkg, skt_if and sorted_key_table.
module testbench;
  import skt_pkg::*;

  localparam int SLOTS = DEF_CAPACITY;

  typedef struct packed {
    logic                mode;
    logic [KEY_IN_W-1:0] key;
  } op_item_t;

  typedef struct packed {
    status_t             status;
    logic [POS_W-1:0]    position;
    logic [KEY_IN_W-1:0] removed_key;
    logic [POS_W-1:0]    entry_count;
  } op_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  skt_in_if  op_bus();
  skt_out_if res_bus();

  sorted_key_table uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (op_bus),
    .out_ch    (res_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the key table
  logic [KEY_IN_W-1:0] tbl_keys [SLOTS];
  int                  tbl_fill;
  bit                  ord_signed;

  op_item_t            op_queue[$];
  op_result_t          pending_results[$];
  logic [KEY_IN_W-1:0] key_pool[$];
  int                  bad_results;
  bit                  in_acc, out_acc;
  bit                  calm;
  int                  in_gap, res_stall;

  function automatic logic [KEY_IN_W-1:0] rank(logic [KEY_IN_W-1:0] v);
    return ord_signed ? (v ^ (32'h1 << (KEY_IN_W - 1))) : v;
  endfunction

  function automatic op_result_t apply_key_op(logic mode, logic [KEY_IN_W-1:0] k);
    op_result_t r;
    int lo, hi, mid;
    bit hit;
    lo = 0;
    hi = tbl_fill;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (rank(tbl_keys[mid]) < rank(k)) lo = mid + 1;
      else hi = mid;
    end
    hit = (lo < tbl_fill) && (tbl_keys[lo] == k);
    r.removed_key = '0;
    if (mode == MODE_INSERT) begin
      if (hit) begin
        r.status = ST_DUPLICATE;
      end else if (tbl_fill >= SLOTS) begin
        r.status = ST_FULL;
      end else begin
        for (int i = tbl_fill; i > lo; i--) tbl_keys[i] = tbl_keys[i-1];
        tbl_keys[lo] = k;
        tbl_fill++;
        r.status = ST_INSERTED;
      end
    end else begin
      if (hit) begin
        r.removed_key = tbl_keys[lo];
        for (int i = lo; i < tbl_fill - 1; i++) tbl_keys[i] = tbl_keys[i+1];
        tbl_fill--;
        r.status = ST_ERASED;
      end else begin
        r.status = ST_NOT_FOUND;
      end
    end
    r.position    = lo[POS_W-1:0];
    r.entry_count = tbl_fill[POS_W-1:0];
    return r;
  endfunction

  // Scoreboard: check results first, then predict for the item taken at this edge
  always @(posedge clk) begin : score_proc
    op_result_t exp_r;
    in_acc  = rst_n && op_bus.valid && op_bus.ready;
    out_acc = rst_n && res_bus.valid && res_bus.ready;
    if (out_acc) begin
      if (pending_results.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("%0t: unexpected result status=%0d pos=%0d removed=%h count=%0d", $realtime,
                   res_bus.status, res_bus.position, res_bus.removed_key, res_bus.entry_count);
      end else begin
        exp_r = pending_results.pop_front();
        if (res_bus.status !== exp_r.status || res_bus.position !== exp_r.position ||
            res_bus.removed_key !== exp_r.removed_key ||
            res_bus.entry_count !== exp_r.entry_count) begin
          bad_results++;
          if (bad_results <= 10) begin
            $display("%0t: mismatch exp status=%0d pos=%0d removed=%h count=%0d",
                     $realtime, exp_r.status, exp_r.position, exp_r.removed_key,
                     exp_r.entry_count);
            $display("%0t:          got status=%0d pos=%0d removed=%h count=%0d",
                     $realtime, res_bus.status, res_bus.position,
                     res_bus.removed_key, res_bus.entry_count);
          end
        end
      end
    end
    if (in_acc) pending_results.push_back(apply_key_op(op_bus.mode, op_bus.key));
  end

  // Driver
  always @(negedge clk) begin : drive_proc
    op_item_t it;
    bit nv;
    if (rst_n && !(op_bus.valid && !in_acc)) begin
      nv = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (op_queue.size() != 0) begin
        it = op_queue.pop_front();
        op_bus.mode <= it.mode;
        op_bus.key  <= it.key;
        nv = 1'b1;
        if ($urandom_range(0, 39) == 0) calm = !calm;
        in_gap = calm ? 0 : $urandom_range(0, 6);
      end
      op_bus.valid <= nv;
    end
  end

  // Result acceptance with random back-pressure
  always @(negedge clk) begin
    if (out_acc) res_stall = calm ? 0 : $urandom_range(0, 6);
    if (res_stall > 0) begin
      res_stall--;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= 1'b1;
    end
  end

  task automatic post(logic mode, logic [KEY_IN_W-1:0] k);
    op_item_t it;
    it.mode = mode;
    it.key  = k;
    op_queue.push_back(it);
  endtask

  task automatic wait_quiet();
    while (op_queue.size() != 0 || op_bus.valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_order(bit v);
    wait_quiet();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    ord_signed = v;
  endtask

  // Erase every held key in random order
  task automatic drain_table();
    logic [KEY_IN_W-1:0] held[$];
    logic [KEY_IN_W-1:0] t;
    int j;
    wait_quiet();
    for (int i = 0; i < tbl_fill; i++) held.push_back(tbl_keys[i]);
    for (int i = held.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = held[i];
      held[i] = held[j];
      held[j] = t;
    end
    foreach (held[i]) post(MODE_ERASE, held[i]);
    wait_quiet();
  endtask

  task automatic build_pool();
    int n;
    key_pool = '{32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h8000_0001, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
    n = $urandom_range(60, 90);
    repeat (n) key_pool.push_back($urandom());
  endtask

  function automatic logic [KEY_IN_W-1:0] draw_key();
    if ($urandom_range(0, 3) != 0) return key_pool[$urandom_range(0, key_pool.size() - 1)];
    return $urandom();
  endfunction

  // Fill an empty table to capacity, then hit it with a new key, a held key and a miss
  task automatic fill_table();
    bit seen [logic [KEY_IN_W-1:0]];
    logic [KEY_IN_W-1:0] k;
    logic [KEY_IN_W-1:0] first;
    for (int i = 0; i < SLOTS; i++) begin
      do k = draw_key(); while (seen.exists(k));
      seen[k] = 1'b1;
      if (i == 0) first = k;
      post(MODE_INSERT, k);
    end
    do k = $urandom(); while (seen.exists(k));
    post(MODE_INSERT, k);
    post(MODE_INSERT, first);
    post(MODE_ERASE, k);
  endtask

  task automatic run_phase(int n);
    int ins_pct;
    for (int i = 0; i < n; i++) begin
      ins_pct = (i < n / 2) ? 70 : 35;
      post(($urandom_range(0, 99) < ins_pct) ? MODE_INSERT : MODE_ERASE, draw_key());
    end
  endtask

  initial begin : stim_proc
    bit order_plan [8];
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = 1'b0;
    op_bus.valid  = 1'b0;
    op_bus.mode   = MODE_INSERT;
    op_bus.key    = '0;
    res_bus.ready = 1'b0;
    tbl_fill      = 0;
    ord_signed    = 1'b0;
    bad_results   = 0;
    calm          = 1'b0;
    in_gap        = 0;
    res_stall     = 0;
    order_plan    = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed, unsigned order
    set_order(1'b0);
    post(MODE_ERASE,  32'h0000_0005);
    post(MODE_INSERT, 32'h0000_0000);
    post(MODE_INSERT, 32'hFFFF_FFFF);
    post(MODE_INSERT, 32'h8000_0000);
    post(MODE_INSERT, 32'h7FFF_FFFF);
    post(MODE_INSERT, 32'h0000_0000);
    post(MODE_INSERT, 32'h8000_0000);
    post(MODE_ERASE,  32'h0001_2345);
    post(MODE_ERASE,  32'hFFFF_FFFF);
    post(MODE_ERASE,  32'h0000_0000);
    post(MODE_INSERT, 32'h0000_0001);
    post(MODE_INSERT, 32'hFFFF_FFFE);
    post(MODE_ERASE,  32'h8000_0000);
    post(MODE_ERASE,  32'h7FFF_FFFF);
    drain_table();

    // Directed, signed order
    set_order(1'b1);
    post(MODE_INSERT, 32'h8000_0000);
    post(MODE_INSERT, 32'h7FFF_FFFF);
    post(MODE_INSERT, 32'hFFFF_FFFF);
    post(MODE_INSERT, 32'h0000_0000);
    post(MODE_ERASE,  32'h8000_0000);
    post(MODE_ERASE,  32'h7FFF_FFFF);
    drain_table();

    foreach (order_plan[p]) begin
      set_order(order_plan[p]);
      build_pool();
      if (p == 2 || p == 5) fill_table();
      run_phase(150);
      drain_table();
    end

    wait_quiet();
    repeat (8) @(posedge clk);
    if (bad_results == 0 && pending_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/skt_pkg.sv
rtl/skt_if.sv
rtl/skt_cell.sv
rtl/skt_pos_enc.sv
rtl/sorted_key_table.sv
tb/testbench.sv
